>>> rtl/core/sts_pkg.sv
// shared types and constants of the sorted-table search block
package sts_pkg;

   // fixed field widths of the request and response words
   localparam int POS_W   = 10;
   localparam int FIELD_W = 32;
   localparam int PROBE_W = POS_W + 1;

   // defaults for the top-level parameters
   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // request operation codes
   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_SEARCH = 1'b1
   } func_type;

   // search sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE
   } state_type;

   // request word
   typedef struct packed {
      func_type                   func;
      logic [POS_W-1:0]           entry_position;
      logic signed [FIELD_W-1:0]  entry_value;
      logic signed [FIELD_W-1:0]  search_key;
      logic [POS_W-1:0]           range_low;
      logic [POS_W-1:0]           range_high;
   } req_word_type;

   // response word
   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] found_position;
   } rsp_word_type;

   // table memory strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

>>> rtl/core/sts_table_mem.sv
// single-port table memory with registered read data
module sts_table_mem #(
   parameter int DEPTH = sts_pkg::TABLE_DEPTH_DEFAULT,
   parameter int WIDTH = sts_pkg::VALUE_WIDTH_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  sts_pkg::mem_ctl_type  mem_ctl,
   input  logic [AW-1:0]         addr,
   input  logic [WIDTH-1:0]      wr_data,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] table_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read share the one address
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         table_ff[addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= table_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sts_search_ctrl.sv
// command decode and binary-search sequencer
module sts_search_ctrl #(
   parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = sts_pkg::VALUE_WIDTH_DEFAULT,
   localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  sts_pkg::req_word_type  req_word,
   output logic                   busy,
   output logic                   rsp_valid,
   output sts_pkg::rsp_word_type  rsp_word,
   output sts_pkg::mem_ctl_type   mem_ctl,
   output logic [AW-1:0]          mem_addr,
   output logic [VALUE_WIDTH-1:0] mem_wr_data,
   input  logic [VALUE_WIDTH-1:0] mem_rd_data
);

   localparam int POS_W   = sts_pkg::POS_W;
   localparam int PROBE_W = sts_pkg::PROBE_W;

   sts_pkg::state_type state_ff, state_in;

   logic signed [PROBE_W-1:0]     low_ff, low_in;
   logic signed [PROBE_W-1:0]     high_ff, high_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [POS_W-1:0]              mid_ff, mid_in;
   logic                          in_range_ff, in_range_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sts_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;

   logic                          range_empty;
   logic [PROBE_W-1:0]            mid_sum;
   logic [POS_W-1:0]              mid;
   logic signed [VALUE_WIDTH-1:0] probe_value;
   logic                          probe_hit;
   logic                          key_below;
   logic                          wr_in_table;

   // midpoint of the live bounds, both within 0..1023 when the range is not empty
   // low runs 0..1024 and high -1..1023, so a set sign bit on high marks the -1 bound
   assign range_empty = high_ff[PROBE_W-1] || ($unsigned(low_ff) > $unsigned(high_ff));
   assign mid_sum     = {1'b0, low_ff[POS_W-1:0]} + {1'b0, high_ff[POS_W-1:0]};
   assign mid         = mid_sum[PROBE_W-1:1];

   // entries past the table read as zero
   assign probe_value = in_range_ff ? $signed(mem_rd_data) : '0;
   assign probe_hit   = probe_value == key_ff;
   assign key_below   = key_ff < probe_value;

   assign wr_in_table = 32'(req_word.entry_position) < TABLE_DEPTH;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sts_pkg::ST_IDLE: begin
            if (start && req_word.func == sts_pkg::FUNC_SEARCH) begin
               state_in = sts_pkg::ST_PROBE;
            end
         end
         sts_pkg::ST_PROBE: begin
            state_in = range_empty ? sts_pkg::ST_IDLE : sts_pkg::ST_COMPARE;
         end
         sts_pkg::ST_COMPARE: begin
            state_in = probe_hit ? sts_pkg::ST_IDLE : sts_pkg::ST_PROBE;
         end
         default: begin
            state_in = sts_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      busy         = 1'b1;
      mem_ctl      = '0;
      mem_addr     = AW'(mid);
      mem_wr_data  = VALUE_WIDTH'($signed(req_word.entry_value));
      low_in       = low_ff;
      high_in      = high_ff;
      key_in       = key_ff;
      mid_in       = mid_ff;
      in_range_in  = in_range_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      unique case (state_ff)
         sts_pkg::ST_IDLE: begin
            busy     = 1'b0;
            mem_addr = AW'(req_word.entry_position);
            if (start) begin
               if (req_word.func == sts_pkg::FUNC_WRITE) begin
                  mem_ctl.wr_en = wr_in_table;
               end else begin
                  low_in  = {1'b0, req_word.range_low};
                  high_in = {1'b0, req_word.range_high};
                  key_in  = VALUE_WIDTH'($signed(req_word.search_key));
               end
            end
         end
         sts_pkg::ST_PROBE: begin
            if (range_empty) begin
               rsp_valid_in               = 1'b1;
               rsp_word_in.found          = 1'b0;
               rsp_word_in.found_position = '0;
            end else begin
               mem_ctl.rd_en = 1'b1;
               mid_in        = mid;
               in_range_in   = 32'(mid) < TABLE_DEPTH;
            end
         end
         sts_pkg::ST_COMPARE: begin
            // match ends the search, else narrow to the half that can hold the key
            if (probe_hit) begin
               rsp_valid_in               = 1'b1;
               rsp_word_in.found          = 1'b1;
               rsp_word_in.found_position = mid_ff;
            end else if (key_below) begin
               high_in = PROBE_W'({1'b0, mid_ff} - PROBE_W'(1));
            end else begin
               low_in = PROBE_W'({1'b0, mid_ff} + PROBE_W'(1));
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // control and probe bound registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         low_ff       <= '0;
         high_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      mid_ff      <= mid_in;
      in_range_ff <= in_range_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> rtl/core/sorted_table_binary_search.sv
// Sorted-table binary search. A word is taken when start is high and busy is low.
// A write word stores one value into the table in that cycle if its position lies
// inside the table, and never raises busy. A search word halves its inclusive
// position range around the midpoint until the key matches or the range empties,
// then shows one response word for exactly one cycle on rsp_valid; the receiver
// must take it then, it cannot hold it off. Each probe takes a registered table
// read in the probe state, then a compare in the compare state that narrows the
// bounds; a miss ends with a further probe state that finds the range empty. The
// next word can be taken in the cycle that shows the response (a search holds at
// most 11 probes over a 1024-entry range). The table is not cleared at reset:
// every entry must be written before a search reads it.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = sts_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sts_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output sts_pkg::rsp_word_type rsp_word
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   sts_pkg::mem_ctl_type   mem_ctl;
   logic [AW-1:0]          mem_addr;
   logic [VALUE_WIDTH-1:0] mem_wr_data;
   logic [VALUE_WIDTH-1:0] mem_rd_data;

   // sequencer
   sts_search_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_word    (req_word),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .mem_ctl     (mem_ctl),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   // table storage
   sts_table_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (VALUE_WIDTH)
   ) u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // a response strobe is never held high back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // a response only follows a cycle of search work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a search in progress");

   // a write word gives no response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.func == sts_pkg::FUNC_WRITE) |=> !rsp_valid)
      else $error("write word produced a response");

   // an accepted search occupies the block
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.func == sts_pkg::FUNC_SEARCH) |=> busy)
      else $error("search accepted without raising busy");

endmodule
